// ----- hw/rtl/kdc_pkg.sv -----
// Package for the key debounce and click detector.
// Holds the per-key entry layout, the state codes, configuration defaults and shared types.
// No dependencies.
`timescale 1ns / 1ps

package kdc_pkg;

  // Field widths of the item channels and the configuration port.
  localparam int unsigned KeyW    = 4;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ScanW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // Default number of keys.
  localparam int unsigned NumKeysDefault = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegScanInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLongPress    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDoubleClick  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegActiveLevel  = 2'd3;

  // Configuration reset values.
  localparam logic [ScanW-1:0]  ScanIntervalRst = 8'd10;
  localparam logic [TimerW-1:0] LongPressRst    = 16'd1000;
  localparam logic [TimerW-1:0] DoubleClickRst  = 16'd300;
  localparam logic [CfgW-1:0]   ActiveLevelRst  = 16'd0;

  // Click event codes.
  localparam logic [1:0] EvNone   = 2'd0;
  localparam logic [1:0] EvSingle = 2'd1;
  localparam logic [1:0] EvMulti  = 2'd2;

  localparam logic [CountW-1:0] CountMax = '1;

  // Debounce states.
  typedef enum logic [1:0] {
    DbReleased = 2'd0,
    DbDown     = 2'd1,
    DbPressed  = 2'd2,
    DbUp       = 2'd3
  } db_state_e;

  // Click phases; the two remaining codes are unused.
  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhPressed = 3'd1,
    PhWait2   = 3'd2,
    PhWaitN   = 3'd3,
    PhConfirm = 3'd4,
    PhLong    = 3'd5
  } phase_e;

  // One key's stored state.
  typedef struct packed {
    db_state_e         db;
    phase_e            phase;
    logic [TimerW-1:0] press_timer;
    logic [TimerW-1:0] gap_timer;
    logic [CountW-1:0] click_count;
    logic              long_reported;
  } kdc_entry_t;

  localparam int unsigned EntryW = $bits(kdc_entry_t);

  localparam kdc_entry_t EntryRst = '{
    db:            DbReleased,
    phase:         PhIdle,
    press_timer:   '0,
    gap_timer:     '0,
    click_count:   '0,
    long_reported: 1'b0
  };

  // Timing configuration seen by the update logic.
  typedef struct packed {
    logic [ScanW-1:0]  scan_interval;
    logic [TimerW-1:0] long_press;
    logic [TimerW-1:0] double_click;
  } kdc_cfg_t;

  // Result fields of one item.
  typedef struct packed {
    logic              debounced_pressed;
    logic [1:0]        click_event;
    logic [CountW-1:0] click_total;
    logic              long_start;
    logic              long_release;
  } kdc_res_t;

endpackage

// ----- hw/rtl/kdc_if.sv -----
// Valid/ready channel interfaces for scan ticks and results.
// Depends on kdc_pkg for the field widths.
`timescale 1ns / 1ps

interface kdc_in_if
  import kdc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key_index;
  logic            raw_level;

  modport source (output valid, key_index, raw_level, input ready);
  modport sink   (input valid, key_index, raw_level, output ready);
endinterface

interface kdc_out_if
  import kdc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KeyW-1:0]   key_echo;
  logic              debounced_pressed;
  logic [1:0]        click_event;
  logic [CountW-1:0] click_total;
  logic              long_start;
  logic              long_release;

  modport source (output valid, key_echo, debounced_pressed, click_event, click_total,
                  long_start, long_release, input ready);
  modport sink   (input valid, key_echo, debounced_pressed, click_event, click_total,
                  long_start, long_release, output ready);
endinterface

// ----- hw/rtl/kdc_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module kdc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/kdc_update.sv -----
// Next-state logic for one key: debounce machine, click machine and result fields.
// Depends on kdc_pkg.
`timescale 1ns / 1ps

module kdc_update
  import kdc_pkg::*;
(
  input  kdc_entry_t cur_i,
  input  logic       raw_level_i,
  input  logic       active_level_i,
  input  kdc_cfg_t   cfg_i,
  output kdc_entry_t nxt_o,
  output kdc_res_t   res_o
);

  logic              hit;
  db_state_e         db_nxt;
  logic [TimerW-1:0] press_inc;
  logic [TimerW-1:0] gap_inc;

  // Saturating add of the scan interval to a timer.
  function automatic logic [TimerW-1:0] sat_add(logic [TimerW-1:0] a, logic [ScanW-1:0] b);
    logic [TimerW:0] s;
    s = {1'b0, a} + (TimerW+1)'(b);
    return s[TimerW] ? '1 : s[TimerW-1:0];
  endfunction

  assign hit       = (raw_level_i == active_level_i);
  assign press_inc = sat_add(cur_i.press_timer, cfg_i.scan_interval);
  assign gap_inc   = sat_add(cur_i.gap_timer, cfg_i.scan_interval);

  // Debounce machine.
  always_comb begin
    case (cur_i.db)
      DbReleased: db_nxt = hit ? DbDown : DbReleased;
      DbDown:     db_nxt = hit ? DbPressed : DbReleased;
      DbPressed:  db_nxt = hit ? DbPressed : DbUp;
      default:    db_nxt = hit ? DbPressed : DbReleased;
    endcase
  end

  // Click machine, driven by the new debounced state.
  always_comb begin
    nxt_o                   = cur_i;
    nxt_o.db                = db_nxt;
    res_o                   = '0;
    res_o.debounced_pressed = (db_nxt == DbPressed);
    case (cur_i.phase)
      PhIdle: begin
        if (db_nxt == DbPressed) begin
          nxt_o.phase         = PhPressed;
          nxt_o.press_timer   = '0;
          nxt_o.long_reported = 1'b0;
          nxt_o.click_count   = '0;
        end
      end
      PhPressed: begin
        if (db_nxt == DbPressed) begin
          nxt_o.press_timer = press_inc;
          if (press_inc >= cfg_i.long_press) begin
            nxt_o.phase = PhLong;
          end
        end else begin
          nxt_o.phase     = PhWait2;
          nxt_o.gap_timer = '0;
        end
      end
      PhWait2: begin
        nxt_o.gap_timer = gap_inc;
        if (db_nxt == DbPressed) begin
          nxt_o.phase       = PhWaitN;
          nxt_o.click_count = CountW'(1);
          nxt_o.gap_timer   = '0;
        end else if (gap_inc >= cfg_i.double_click) begin
          nxt_o.phase       = PhIdle;
          res_o.click_event = EvSingle;
        end
      end
      PhWaitN: begin
        nxt_o.gap_timer = gap_inc;
        if (db_nxt == DbPressed) begin
          nxt_o.phase = PhConfirm;
        end else if (gap_inc >= cfg_i.double_click) begin
          nxt_o.phase       = PhIdle;
          res_o.click_event = EvMulti;
          res_o.click_total = cur_i.click_count;
        end
      end
      PhConfirm: begin
        if (db_nxt == DbReleased) begin
          if (cur_i.click_count != CountMax) begin
            nxt_o.click_count = cur_i.click_count + CountW'(1);
          end
          nxt_o.phase     = PhWaitN;
          nxt_o.gap_timer = '0;
        end
      end
      PhLong: begin
        if (!cur_i.long_reported) begin
          nxt_o.long_reported = 1'b1;
          res_o.long_start    = 1'b1;
          res_o.click_total   = cur_i.click_count;
        end
        if (db_nxt == DbReleased) begin
          res_o.long_release  = 1'b1;
          nxt_o.phase         = PhIdle;
          nxt_o.long_reported = 1'b0;
        end
      end
      default: begin
        // Unused phase codes hold their phase and report no click events.
      end
    endcase
  end

endmodule

// ----- hw/rtl/key_debounce_click_detector.sv -----
// Top level of the key debounce and click detector.
// Depends on kdc_pkg, kdc_if, kdc_ram and kdc_update.
`timescale 1ns / 1ps

// Each item is one scan tick for one key and yields exactly one result item. Per-key state
// lives in one RAM with a registered read port; an item reads its key's entry when accepted, is
// updated and written back, and its result registered, when the update stage advances. One item
// is accepted per cycle while the output is not stalled, also for the same key back to back,
// since the entry just written is forwarded to the next item. Per-entry valid bits make every
// key read as released and idle after reset, so no clearing pass is needed. Keys at or above
// NUM_KEYS change nothing and report only their index. Configure only while the block is idle.
module key_debounce_click_detector
  import kdc_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NumKeysDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  kdc_in_if.sink             in_ch_i,
  kdc_out_if.source          out_ch_o
);

  localparam int unsigned AddrW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // Configuration registers.
  logic [ScanW-1:0]  scan_interval_q;
  logic [TimerW-1:0] long_press_q;
  logic [TimerW-1:0] double_click_q;
  logic [CfgW-1:0]   active_level_q;

  // Update stage registers.
  logic            s1_valid_q;
  logic [KeyW-1:0] s1_key_q;
  logic            s1_level_q;
  logic            s1_in_range_q;

  // Forwarding of the last written entry.
  logic             fwd_valid_q;
  logic [AddrW-1:0] fwd_addr_q;
  kdc_entry_t       fwd_data_q;

  logic [NUM_KEYS-1:0] entry_vld_q;

  // Output register.
  logic            out_valid_q;
  logic [KeyW-1:0] out_key_q;
  kdc_res_t        out_res_q;

  logic             in_accept;
  logic             s1_advance;
  logic             s1_write;
  logic [AddrW-1:0] in_addr;
  logic [AddrW-1:0] s1_addr;
  logic [EntryW-1:0] ram_rdata;
  kdc_entry_t       cur_entry;
  kdc_entry_t       nxt_entry;
  kdc_res_t         upd_res;
  kdc_cfg_t         upd_cfg;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_interval_q <= ScanIntervalRst;
      long_press_q    <= LongPressRst;
      double_click_q  <= DoubleClickRst;
      active_level_q  <= ActiveLevelRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegScanInterval: scan_interval_q <= cfg_data_i[ScanW-1:0];
        RegLongPress:    long_press_q    <= cfg_data_i;
        RegDoubleClick:  double_click_q  <= cfg_data_i;
        RegActiveLevel:  active_level_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the update stage moves on whenever the output register is free or drains.
  assign s1_advance     = s1_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready  = !s1_valid_q || s1_advance;
  assign in_accept      = in_ch_i.valid && in_ch_i.ready;
  assign in_addr        = AddrW'(in_ch_i.key_index);
  assign s1_addr        = AddrW'(s1_key_q);
  assign s1_write       = s1_advance && s1_in_range_q;

  // Per-key state memory.
  kdc_ram #(
    .Width (EntryW),
    .Depth (NUM_KEYS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_addr),
    .wdata_i (nxt_entry),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // Current entry: forwarded write, else memory if written since reset, else reset value.
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_addr)) begin
      cur_entry = fwd_data_q;
    end else if (entry_vld_q[s1_addr]) begin
      cur_entry = kdc_entry_t'(ram_rdata);
    end else begin
      cur_entry = EntryRst;
    end
  end

  assign upd_cfg = '{
    scan_interval: scan_interval_q,
    long_press:    long_press_q,
    double_click:  double_click_q
  };

  kdc_update u_update (
    .cur_i          (cur_entry),
    .raw_level_i    (s1_level_q),
    .active_level_i (active_level_q[s1_key_q]),
    .cfg_i          (upd_cfg),
    .nxt_o          (nxt_entry),
    .res_o          (upd_res)
  );

  // Update stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      s1_valid_q <= in_ch_i.valid;
    end
  end

  // Update stage payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_key_q      <= in_ch_i.key_index;
      s1_level_q    <= in_ch_i.raw_level;
      s1_in_range_q <= (32'(in_ch_i.key_index) < NUM_KEYS);
    end
  end

  // Valid bits and forwarding register track each write-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      fwd_valid_q <= 1'b0;
    end else if (s1_write) begin
      entry_vld_q[s1_addr] <= 1'b1;
      fwd_valid_q          <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_write) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= nxt_entry;
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ch_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Output register payload; keys out of range report only their index.
  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_key_q <= s1_key_q;
      out_res_q <= s1_in_range_q ? upd_res : '0;
    end
  end

  assign out_ch_o.valid             = out_valid_q;
  assign out_ch_o.key_echo          = out_key_q;
  assign out_ch_o.debounced_pressed = out_res_q.debounced_pressed;
  assign out_ch_o.click_event       = out_res_q.click_event;
  assign out_ch_o.click_total       = out_res_q.click_total;
  assign out_ch_o.long_start        = out_res_q.long_start;
  assign out_ch_o.long_release      = out_res_q.long_release;

endmodule

// ----- sim/kdc_click_checker.sv -----
// Result checker for the key debounce and click detector testbench.
// Watches the scan-tick, result and configuration ports, predicts each result and compares.
// Depends on kdc_pkg and the channel interfaces in kdc_if.
`timescale 1ns / 1ps

module kdc_click_checker
  import kdc_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NumKeysDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  kdc_in_if                  tick_ch,
  kdc_out_if                 res_ch,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 singles_o,
  output int                 multis_o,
  output int                 long_starts_o,
  output int                 long_releases_o,
  output int                 max_total_o
);

  localparam int unsigned IndexSpan = 1 << KeyW;

  // One predicted result, tagged with the key it belongs to.
  typedef struct packed {
    logic [KeyW-1:0] key;
    kdc_res_t        res;
  } key_result_t;

  // Predicted per-key state, one slot for every index the key field can carry.
  db_state_e         key_db        [IndexSpan];
  phase_e            key_phase     [IndexSpan];
  logic [TimerW-1:0] key_press_ms  [IndexSpan];
  logic [TimerW-1:0] key_gap_ms    [IndexSpan];
  logic [CountW-1:0] key_clicks    [IndexSpan];
  logic              key_long_seen [IndexSpan];

  // Predicted configuration.
  logic [ScanW-1:0]  cfg_scan;
  logic [TimerW-1:0] cfg_long;
  logic [TimerW-1:0] cfg_dbl;
  logic [CfgW-1:0]   cfg_active;

  key_result_t expected_clicks_q[$];
  int fails, n_results, n_single, n_multi, n_lstart, n_lrel, max_total;

  function automatic logic [TimerW-1:0] add_sat(input logic [TimerW-1:0] a,
                                                input logic [ScanW-1:0] b);
    logic [TimerW:0] sum;
    sum = {1'b0, a} + (TimerW+1)'(b);
    return sum[TimerW] ? '1 : sum[TimerW-1:0];
  endfunction

  // Advances the predicted state of one key by one scan tick and returns its result.
  function automatic kdc_res_t scan_key_tick(input logic [KeyW-1:0] k, input logic lvl);
    kdc_res_t  r;
    logic      hit;
    db_state_e db;
    phase_e    ph;
    r = '0;
    if (k >= NUM_KEYS) return r;

    // Debounce: two matching samples are needed to enter the pressed state; one mismatch leaves it.
    hit = (lvl == cfg_active[k]);
    case (key_db[k])
      DbReleased: db = hit ? DbDown : DbReleased;
      DbDown:     db = hit ? DbPressed : DbReleased;
      DbPressed:  db = hit ? DbPressed : DbUp;
      default:    db = hit ? DbPressed : DbReleased;
    endcase
    key_db[k] = db;

    // Click machine, driven by the new debounced state.
    ph = key_phase[k];
    case (key_phase[k])
      PhIdle: begin
        if (db == DbPressed) begin
          ph = PhPressed;
          key_press_ms[k]  = '0;
          key_long_seen[k] = 1'b0;
          key_clicks[k]    = '0;
        end
      end
      PhPressed: begin
        // Anything but a firm press, an up-shake included, counts as a release here.
        if (db == DbPressed) begin
          key_press_ms[k] = add_sat(key_press_ms[k], cfg_scan);
          if (key_press_ms[k] >= cfg_long) ph = PhLong;
        end else begin
          ph = PhWait2;
          key_gap_ms[k] = '0;
        end
      end
      PhWait2: begin
        key_gap_ms[k] = add_sat(key_gap_ms[k], cfg_scan);
        if (db == DbPressed) begin
          ph = PhWaitN;
          key_clicks[k] = 8'd1;
          key_gap_ms[k] = '0;
        end else if (key_gap_ms[k] >= cfg_dbl) begin
          ph = PhIdle;
          r.click_event = EvSingle;
        end
      end
      PhWaitN: begin
        key_gap_ms[k] = add_sat(key_gap_ms[k], cfg_scan);
        if (db == DbPressed) begin
          ph = PhConfirm;
        end else if (key_gap_ms[k] >= cfg_dbl) begin
          ph = PhIdle;
          r.click_event = EvMulti;
          r.click_total = key_clicks[k];
        end
      end
      PhConfirm: begin
        if (db == DbReleased) begin
          if (key_clicks[k] != CountMax) key_clicks[k]++;
          ph = PhWaitN;
          key_gap_ms[k] = '0;
        end
      end
      PhLong: begin
        if (!key_long_seen[k]) begin
          key_long_seen[k] = 1'b1;
          r.long_start  = 1'b1;
          r.click_total = key_clicks[k];
        end
        if (db == DbReleased) begin
          r.long_release   = 1'b1;
          ph               = PhIdle;
          key_long_seen[k] = 1'b0;
        end
      end
      default: ;
    endcase
    key_phase[k] = ph;

    r.debounced_pressed = (db == DbPressed);
    return r;
  endfunction

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    fails++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  // Predict on every accepted tick, compare on every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin : track
    key_result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < IndexSpan; k++) begin
        key_db[k]        = DbReleased;
        key_phase[k]     = PhIdle;
        key_press_ms[k]  = '0;
        key_gap_ms[k]    = '0;
        key_clicks[k]    = '0;
        key_long_seen[k] = 1'b0;
      end
      cfg_scan   = ScanIntervalRst;
      cfg_long   = LongPressRst;
      cfg_dbl    = DoubleClickRst;
      cfg_active = ActiveLevelRst;
      expected_clicks_q.delete();
      fails     = 0;
      n_results = 0;
      n_single  = 0;
      n_multi   = 0;
      n_lstart  = 0;
      n_lrel    = 0;
      max_total = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegScanInterval: cfg_scan   = cfg_data_i[ScanW-1:0];
          RegLongPress:    cfg_long   = cfg_data_i[TimerW-1:0];
          RegDoubleClick:  cfg_dbl    = cfg_data_i[TimerW-1:0];
          RegActiveLevel:  cfg_active = cfg_data_i;
          default: ;
        endcase
      end

      if (tick_ch.valid && tick_ch.ready) begin
        want.key = tick_ch.key_index;
        want.res = scan_key_tick(tick_ch.key_index, tick_ch.raw_level);
        expected_clicks_q.push_back(want);
      end

      if (res_ch.valid && res_ch.ready) begin
        if (expected_clicks_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual key %0d", $time,
                   res_ch.key_echo);
        end else begin
          want = expected_clicks_q.pop_front();
          n_results++;
          if (res_ch.key_echo !== want.key)
            report_field("key_echo", 16'(want.key), 16'(res_ch.key_echo));
          if (res_ch.debounced_pressed !== want.res.debounced_pressed)
            report_field("debounced_pressed", 16'(want.res.debounced_pressed),
                         16'(res_ch.debounced_pressed));
          if (res_ch.click_event !== want.res.click_event)
            report_field("click_event", 16'(want.res.click_event), 16'(res_ch.click_event));
          if (res_ch.click_total !== want.res.click_total)
            report_field("click_total", 16'(want.res.click_total), 16'(res_ch.click_total));
          if (res_ch.long_start !== want.res.long_start)
            report_field("long_start", 16'(want.res.long_start), 16'(res_ch.long_start));
          if (res_ch.long_release !== want.res.long_release)
            report_field("long_release", 16'(want.res.long_release),
                         16'(res_ch.long_release));
          if (want.res.click_event == EvSingle) n_single++;
          if (want.res.click_event == EvMulti) n_multi++;
          if (want.res.long_start) n_lstart++;
          if (want.res.long_release) n_lrel++;
          if (int'(want.res.click_total) > max_total) max_total = int'(want.res.click_total);
        end
      end
    end
    fail_count_o    <= fails;
    pending_o       <= expected_clicks_q.size();
    results_o       <= n_results;
    singles_o       <= n_single;
    multis_o        <= n_multi;
    long_starts_o   <= n_lstart;
    long_releases_o <= n_lrel;
    max_total_o     <= max_total;
  end

endmodule

// ----- sim/tb_key_debounce_click_detector.sv -----
// Testbench top for the key debounce and click detector: clock, reset, scan-tick stimulus,
// result-side stalls and the verdict. Depends on kdc_pkg, kdc_if, the block and
// kdc_click_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_key_debounce_click_detector;
  import kdc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int RunCap     = 60;

  typedef enum int {
    SinkOpen,
    SinkCoin,
    SinkQuarter,
    SinkMostly
  } sink_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  int fail_count, pending, n_results, n_single, n_multi, n_lstart, n_lrel, max_total;

  // Stimulus-side view of the configuration, used to pick pressed/released levels and size runs.
  logic [ScanW-1:0]  cur_scan;
  logic [TimerW-1:0] cur_long;
  logic [TimerW-1:0] cur_dbl;
  logic [CfgW-1:0]   cur_mask;

  int burst_left;
  int hold_req;
  int settings_used;
  int cycle_count;
  int run_left [16];
  bit key_down [16];

  kdc_in_if  tick_ch ();
  kdc_out_if res_ch ();

  key_debounce_click_detector DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch_i    (tick_ch),
    .out_ch_o   (res_ch)
  );

  kdc_click_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .tick_ch         (tick_ch),
    .res_ch          (res_ch),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_o       (n_results),
    .singles_o       (n_single),
    .multis_o        (n_multi),
    .long_starts_o   (n_lstart),
    .long_releases_o (n_lrel),
    .max_total_o     (max_total)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: stretches of different stall patterns, plus long hold-offs on request.
  initial begin : result_sink
    int         stretch, served, hold_left, beat;
    sink_mode_e mode;
    stretch   = 0;
    served    = 0;
    hold_left = 0;
    beat      = 0;
    mode      = SinkOpen;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      beat++;
      if (hold_left == 0 && served != hold_req) begin
        served    = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = sink_mode_e'($urandom_range(0, 3));
          stretch = $urandom_range(10, 80);
        end
        stretch--;
        case (mode)
          SinkOpen:    res_ch.ready <= 1'b1;
          SinkCoin:    res_ch.ready <= 1'($urandom_range(0, 1));
          SinkQuarter: res_ch.ready <= (beat % 4 == 0);
          default:     res_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic logic level_for(input int k, input bit down);
    return down ? cur_mask[k] : !cur_mask[k];
  endfunction

  // Offers one item and returns at the edge where it is accepted. Items go out in bursts
  // with random gaps between them.
  task automatic send_tick(input logic [KeyW-1:0] k, input logic lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    tick_ch.valid     <= 1'b1;
    tick_ch.key_index <= k;
    tick_ch.raw_level <= lvl;
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
  endtask

  task automatic press_run(input int k, input bit down, input int n);
    repeat (n) send_tick(KeyW'(k), level_for(k, down));
  endtask

  // Stops offering items and waits until every predicted result has come back.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_timing(input logic [ScanW-1:0] scan, input logic [TimerW-1:0] lp,
                                input logic [TimerW-1:0] dc, input logic [CfgW-1:0] mask);
    // Junk in the upper byte checks that the scan interval is cut to its width.
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegScanInterval;
    cfg_data_i <= {8'($urandom), scan};
    @(posedge clk_i);
    cfg_idx_i  <= RegLongPress;
    cfg_data_i <= lp;
    @(posedge clk_i);
    cfg_idx_i  <= RegDoubleClick;
    cfg_data_i <= dc;
    @(posedge clk_i);
    cfg_idx_i  <= RegActiveLevel;
    cfg_data_i <= mask;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_scan = scan;
    cur_long = lp;
    cur_dbl  = dc;
    cur_mask = mask;
    settings_used++;
  endtask

  // Press and release gestures on a few focus keys, sized to the current timing so that
  // single clicks, multi-clicks and long presses all happen, mixed with bounces and noise.
  task automatic run_gestures(input int n_items, input bit with_hold);
    int k, pick, long_ticks, gap_ticks;
    int focus [3];
    long_ticks = int'(cur_long) / int'(cur_scan) + 3;
    gap_ticks  = int'(cur_dbl) / int'(cur_scan) + 3;
    if (long_ticks > RunCap) long_ticks = RunCap;
    if (gap_ticks > RunCap) gap_ticks = RunCap;
    foreach (focus[i]) focus[i] = $urandom_range(0, 15);
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == n_items / 2) hold_req++;
      if ($urandom_range(0, 99) < 8) begin
        send_tick(KeyW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        continue;
      end
      pick = $urandom_range(0, 3);
      k = (pick < 3) ? focus[pick] : $urandom_range(0, 15);
      if (run_left[k] == 0) begin
        key_down[k] = !key_down[k];
        case ($urandom_range(0, 3))
          0:       run_left[k] = 1;
          1, 2:    run_left[k] = $urandom_range(2, 4);
          default: run_left[k] = (key_down[k] ? long_ticks : gap_ticks) + $urandom_range(0, 3);
        endcase
      end
      run_left[k]--;
      send_tick(KeyW'(k), level_for(k, key_down[k]));
    end
  endtask

  initial begin : stimulus
    int k;
    burst_left    = 0;
    hold_req      = 0;
    settings_used = 1;
    foreach (run_left[i]) begin
      run_left[i] = 0;
      key_down[i] = 1'b0;
    end
    cur_scan = ScanIntervalRst;
    cur_long = LongPressRst;
    cur_dbl  = DoubleClickRst;
    cur_mask = ActiveLevelRst;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= RegScanInterval;
    cfg_data_i        <= '0;
    tick_ch.valid     <= 1'b0;
    tick_ch.key_index <= '0;
    tick_ch.raw_level <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A short random stretch with the reset timing.
    run_gestures(40, 1'b0);
    settle();

    // Directed part: keys 0 and 15 active high, key 3 active low.
    program_timing(8'd100, 16'd200, 16'd250, 16'h8001);
    // Single click on the lowest key.
    press_run(0, 1'b1, 2);
    press_run(0, 1'b0, 4);
    // Long press with its start and release on the highest key.
    press_run(15, 1'b1, 6);
    press_run(15, 1'b0, 2);
    // Up-shake right after the press, then a second click.
    press_run(3, 1'b1, 2);
    press_run(3, 1'b0, 1);
    press_run(3, 1'b1, 2);
    press_run(3, 1'b0, 4);
    settle();

    // Random phases over several timings, the extremes among them.
    program_timing(8'd10, 16'd100, 16'd60, 16'($urandom));
    run_gestures(60, 1'b1);
    settle();
    program_timing(8'd1, 16'd0, 16'd0, 16'h0000);
    run_gestures(60, 1'b0);
    settle();
    program_timing(8'd50, 16'd300, 16'd200, 16'hFFFF);
    run_gestures(60, 1'b1);
    settle();
    program_timing(8'($urandom_range(1, 255)), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(0, 2000)), 16'($urandom));
    run_gestures(60, 1'b0);
    settle();

    // Bring keys 5 and 6 back to idle before the saturation runs.
    program_timing(8'd255, 16'hFFFF, 16'd0, 16'($urandom));
    press_run(5, 1'b0, 6);
    press_run(6, 1'b0, 6);
    settle();

    // Saturation: key 6 is held until its press timer reaches its ceiling and the long press
    // fires, while key 5 clicks often enough for its click count to reach its ceiling and saturate.
    program_timing(8'd255, 16'hFFFF, 16'd2000, cur_mask);
    hold_req++;
    for (int c = 0; c < 258; c++) begin
      press_run(6, 1'b1, 1);
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(7, 15);
        send_tick(KeyW'(k), 1'($urandom_range(0, 1)));
      end
      press_run(5, 1'b1, 2);
      press_run(5, 1'b0, 2);
    end
    press_run(6, 1'b1, 4);
    press_run(6, 1'b0, 3);
    press_run(5, 1'b0, 12);
    settle();

    $display("Ran %0d scan ticks over %0d timing settings with random gaps and stalls.",
             n_results, settings_used);
    $display("Seen: %0d single, %0d multi (largest count %0d), %0d long starts, %0d releases.",
             n_single, n_multi, max_total, n_lstart, n_lrel);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- key_debounce_click_detector.f -----
hw/rtl/kdc_pkg.sv
hw/rtl/kdc_if.sv
hw/rtl/kdc_ram.sv
hw/rtl/kdc_update.sv
hw/rtl/key_debounce_click_detector.sv
sim/kdc_click_checker.sv
sim/tb_key_debounce_click_detector.sv
